// ----- hw/rtl/homography_transfer_error_assert.svh -----
// ----------------------------------------------------------------------------
// homography_transfer_error_assert.svh
// Assertion macros for the checker file. They use clock and reset.
// ----------------------------------------------------------------------------
`ifndef HOMOGRAPHY_TRANSFER_ERROR_ASSERT_SVH
`define HOMOGRAPHY_TRANSFER_ERROR_ASSERT_SVH

// same-cycle implication
`define HTE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> (cons)) else $error(msg);

// implication over a fixed number of cycles
`define HTE_ASSERT_DELAY(label, ante, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

// ----- hw/rtl/hte_pkg.sv -----
// ----------------------------------------------------------------------------
// hte_pkg
// Widths, register indexes and the types shared by the transfer error blocks.
// ----------------------------------------------------------------------------
package hte_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int COEF_WIDTH  = 21;
   localparam int CFG_WIDTH   = 63;
   localparam int NUM_ROWS    = 3;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_ZERO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_ONE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_TWO  = 2'd2;

   // homogeneous 1 in coordinate fraction bits
   localparam int ONE_SHIFT = 8;

   localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
   localparam int MAG_W  = COEF_WIDTH + COORD_WIDTH;
   localparam int W_W    = MAG_W + 1;

   // quotient: 39 integer bits below saturation, 12 fraction bits
   localparam int QUOT_FRAC = 12;
   localparam int QUOT_W    = 51;
   localparam int DVD_W     = QUOT_W + MAG_W;
   localparam int DIV_LAT   = QUOT_W + 1;

   localparam int DST_SHIFT = 4;
   localparam int PROJ_W    = QUOT_W + 2;
   localparam int DSH_W     = COORD_WIDTH + DST_SHIFT;
   localparam int EDIFF_W   = ((PROJ_W > DSH_W) ? PROJ_W : DSH_W) + 1;
   localparam int EMAG_W    = 31;
   localparam int SQ_W      = 2 * EMAG_W;
   localparam int SUM_W     = SQ_W + 1;
   localparam int ERR_SHIFT = 9;
   localparam int SH_W      = SUM_W - ERR_SHIFT;
   localparam int ERR_WIDTH = 48;
   localparam logic [ERR_WIDTH-1:0] ERR_MAX = '1;

   localparam int MAP_LAT = 3;
   localparam int ERR_LAT = 5;
   localparam int LATENCY = MAP_LAT + DIV_LAT + ERR_LAT;

   typedef logic [NUM_ROWS-1:0][CFG_WIDTH-1:0] rows_type;

   typedef struct packed {
      logic                             valid;
      logic [1:0][MAG_W-1:0]            num;
      logic [MAG_W-1:0]                 den;
      logic [1:0]                       neg;
      logic                             degen;
      logic [1:0][COORD_WIDTH-1:0]      dst;
   } map_out_type;

   typedef struct packed {
      logic [1:0]                       neg;
      logic                             degen;
      logic [1:0][COORD_WIDTH-1:0]      dst;
   } side_type;

   typedef struct packed {
      logic [QUOT_W-1:0]                quot;
      logic                             sat;
   } quot_type;

   typedef struct packed {
      logic                             valid;
      logic [1:0][QUOT_W-1:0]           quot;
      logic [1:0]                       sat;
      logic [1:0]                       neg;
      logic                             degen;
      logic [1:0][COORD_WIDTH-1:0]      dst;
   } err_in_type;

endpackage

// ----- hw/rtl/hte_map.sv -----
// ----------------------------------------------------------------------------
// hte_map
// Maps the source point through H: products, row sums, then magnitudes and
// quotient signs for the divider. Three register stages.
// ----------------------------------------------------------------------------
module hte_map (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic signed [hte_pkg::COORD_WIDTH-1:0]  src_x,
   input  logic signed [hte_pkg::COORD_WIDTH-1:0]  src_y,
   input  logic signed [hte_pkg::COORD_WIDTH-1:0]  dst_x,
   input  logic signed [hte_pkg::COORD_WIDTH-1:0]  dst_y,
   input  hte_pkg::rows_type                       rows,
   output hte_pkg::map_out_type                    map_out
);

   logic signed [hte_pkg::PROD_W-1:0]     prod_x_ff [hte_pkg::NUM_ROWS];
   logic signed [hte_pkg::PROD_W-1:0]     prod_y_ff [hte_pkg::NUM_ROWS];
   logic signed [hte_pkg::COEF_WIDTH-1:0] offs_ff   [hte_pkg::NUM_ROWS];
   logic signed [hte_pkg::W_W-1:0]        w_ff      [hte_pkg::NUM_ROWS];
   logic [hte_pkg::MAG_W-1:0]             mag_ff    [hte_pkg::NUM_ROWS];
   logic [1:0]                            neg_ff;
   logic                                  degen_ff;
   logic [1:0][hte_pkg::COORD_WIDTH-1:0]  dst_ff    [hte_pkg::MAP_LAT];
   logic [hte_pkg::MAP_LAT-1:0]           vld_ff;

   for (genvar r = 0; r < hte_pkg::NUM_ROWS; r++) begin : g_row
      logic signed [hte_pkg::COEF_WIDTH-1:0] c0, c1, c2;
      logic signed [hte_pkg::PROD_W-1:0]     prod_x_in, prod_y_in;
      logic signed [hte_pkg::W_W-1:0]        w_in;
      logic [hte_pkg::MAG_W-1:0]             mag_in;

      assign c0 = signed'(rows[r][hte_pkg::COEF_WIDTH-1:0]);
      assign c1 = signed'(rows[r][2*hte_pkg::COEF_WIDTH-1:hte_pkg::COEF_WIDTH]);
      assign c2 = signed'(rows[r][3*hte_pkg::COEF_WIDTH-1:2*hte_pkg::COEF_WIDTH]);

      assign prod_x_in = hte_pkg::PROD_W'(c0) * hte_pkg::PROD_W'(src_x);
      assign prod_y_in = hte_pkg::PROD_W'(c1) * hte_pkg::PROD_W'(src_y);

      assign w_in = hte_pkg::W_W'(prod_x_ff[r]) + hte_pkg::W_W'(prod_y_ff[r])
                  + (hte_pkg::W_W'(offs_ff[r]) <<< hte_pkg::ONE_SHIFT);

      assign mag_in = w_ff[r][hte_pkg::W_W-1] ? hte_pkg::MAG_W'(-w_ff[r])
                                              : hte_pkg::MAG_W'(w_ff[r]);

      always_ff @(posedge clock) begin
         prod_x_ff[r] <= prod_x_in;
         prod_y_ff[r] <= prod_y_in;
         offs_ff[r]   <= c2;
         w_ff[r]      <= w_in;
         mag_ff[r]    <= mag_in;
      end
   end

   // quotient is negative when numerator and w2 differ in sign
   always_ff @(posedge clock) begin
      neg_ff[0] <= w_ff[0][hte_pkg::W_W-1] ^ w_ff[hte_pkg::NUM_ROWS-1][hte_pkg::W_W-1];
      neg_ff[1] <= w_ff[1][hte_pkg::W_W-1] ^ w_ff[hte_pkg::NUM_ROWS-1][hte_pkg::W_W-1];
      degen_ff  <= (w_ff[hte_pkg::NUM_ROWS-1] == '0);
      dst_ff[0] <= {dst_y, dst_x};
      for (int s = 1; s < hte_pkg::MAP_LAT; s++) begin
         dst_ff[s] <= dst_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[hte_pkg::MAP_LAT-2:0], in_valid};
      end
   end

   assign map_out.valid  = vld_ff[hte_pkg::MAP_LAT-1];
   assign map_out.num[0] = mag_ff[0];
   assign map_out.num[1] = mag_ff[1];
   assign map_out.den    = mag_ff[hte_pkg::NUM_ROWS-1];
   assign map_out.neg    = neg_ff;
   assign map_out.degen  = degen_ff;
   assign map_out.dst    = dst_ff[hte_pkg::MAP_LAT-1];

endmodule

// ----- hw/rtl/hte_divider.sv -----
// ----------------------------------------------------------------------------
// hte_divider
// Pipelined restoring divider: floor(num * 2^12 / den), one quotient bit per
// stage, with a saturation flag when the integer part reaches 2^39.
// ----------------------------------------------------------------------------
module hte_divider (
   input  logic                        clock,
   input  logic [hte_pkg::MAG_W-1:0]   num,
   input  logic [hte_pkg::MAG_W-1:0]   den,
   output hte_pkg::quot_type           quot_out
);

   logic [hte_pkg::DVD_W-1:0]  dvd;
   logic [hte_pkg::MAG_W-1:0]  rem_ff [hte_pkg::QUOT_W];
   logic [hte_pkg::MAG_W-1:0]  den_ff [hte_pkg::QUOT_W];
   logic [hte_pkg::QUOT_W-1:0] low_ff [hte_pkg::DIV_LAT];
   logic                       sat_ff [hte_pkg::DIV_LAT];

   assign dvd = hte_pkg::DVD_W'(num) << hte_pkg::QUOT_FRAC;

   // bits above the quotient window stay below den unless the result saturates
   always_ff @(posedge clock) begin
      rem_ff[0] <= dvd[hte_pkg::DVD_W-1:hte_pkg::QUOT_W];
      low_ff[0] <= dvd[hte_pkg::QUOT_W-1:0];
      den_ff[0] <= den;
      sat_ff[0] <= (dvd[hte_pkg::DVD_W-1:hte_pkg::QUOT_W] >= den);
   end

   for (genvar k = 1; k <= hte_pkg::QUOT_W; k++) begin : g_stage
      logic [hte_pkg::MAG_W:0] trial;
      logic                    take;

      assign trial = {rem_ff[k-1], low_ff[k-1][hte_pkg::QUOT_W-1]};
      assign take  = (trial >= {1'b0, den_ff[k-1]});

      always_ff @(posedge clock) begin
         low_ff[k] <= {low_ff[k-1][hte_pkg::QUOT_W-2:0], take};
         sat_ff[k] <= sat_ff[k-1];
      end

      if (k < hte_pkg::QUOT_W) begin : g_rem
         logic [hte_pkg::MAG_W:0] rem_in;

         assign rem_in = take ? (trial - {1'b0, den_ff[k-1]}) : trial;

         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in[hte_pkg::MAG_W-1:0];
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quot_out.quot = low_ff[hte_pkg::QUOT_W];
   assign quot_out.sat  = sat_ff[hte_pkg::QUOT_W];

endmodule

// ----- hw/rtl/hte_error.sv -----
// ----------------------------------------------------------------------------
// hte_error
// Signs the projected point, subtracts the destination, squares and sums the
// components, and saturates the half squared error. Five register stages.
// ----------------------------------------------------------------------------
module hte_error (
   input  logic                              clock,
   input  logic                              reset,
   input  hte_pkg::err_in_type               err_in,
   output logic                              out_valid,
   output logic [hte_pkg::ERR_WIDTH-1:0]     half_sq_error,
   output logic                              degenerate
);

   logic signed [hte_pkg::PROJ_W-1:0]      proj_ff [2];
   logic signed [hte_pkg::COORD_WIDTH-1:0] dst_ff  [2];
   logic signed [hte_pkg::EDIFF_W-1:0]     diff_ff [2];
   logic [hte_pkg::EMAG_W-1:0]             amag_ff [2];
   logic [hte_pkg::SQ_W-1:0]               sq_ff   [2];
   logic [1:0]                             big_in;
   logic [1:0]                             big_ff;
   logic [1:0]                             big_d_ff;
   logic [hte_pkg::ERR_LAT-1:0]            degen_ff;
   logic [hte_pkg::ERR_LAT-1:0]            vld_ff;
   logic [hte_pkg::SUM_W-1:0]              sum;
   logic [hte_pkg::SH_W-1:0]               shifted;
   logic                                   clip;
   logic [hte_pkg::ERR_WIDTH-1:0]          err_in_val;
   logic [hte_pkg::ERR_WIDTH-1:0]          err_ff;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [hte_pkg::PROJ_W-1:0]         m;
      logic [hte_pkg::PROJ_W-1:0]         proj_in;
      logic signed [hte_pkg::EDIFF_W-1:0] diff_in;
      logic [hte_pkg::EDIFF_W-1:0]        amag;
      logic [hte_pkg::SQ_W-1:0]           sq_in;

      assign m = err_in.sat[l] ? (hte_pkg::PROJ_W'(1) << hte_pkg::QUOT_W)
                               : hte_pkg::PROJ_W'(err_in.quot[l]);
      assign proj_in = err_in.neg[l] ? (~m + 1'b1) : m;

      assign diff_in = hte_pkg::EDIFF_W'(proj_ff[l])
                     - (hte_pkg::EDIFF_W'(dst_ff[l]) <<< hte_pkg::DST_SHIFT);

      assign amag = diff_ff[l][hte_pkg::EDIFF_W-1] ? hte_pkg::EDIFF_W'(-diff_ff[l])
                                                   : hte_pkg::EDIFF_W'(diff_ff[l]);
      assign big_in[l] = |amag[hte_pkg::EDIFF_W-1:hte_pkg::EMAG_W];

      assign sq_in = hte_pkg::SQ_W'(amag_ff[l]) * hte_pkg::SQ_W'(amag_ff[l]);

      always_ff @(posedge clock) begin
         proj_ff[l] <= signed'(proj_in);
         dst_ff[l]  <= signed'(err_in.dst[l]);
         diff_ff[l] <= diff_in;
         amag_ff[l] <= amag[hte_pkg::EMAG_W-1:0];
         sq_ff[l]   <= sq_in;
      end
   end

   assign sum     = hte_pkg::SUM_W'(sq_ff[0]) + hte_pkg::SUM_W'(sq_ff[1]);
   assign shifted = sum[hte_pkg::SUM_W-1:hte_pkg::ERR_SHIFT];
   assign clip    = degen_ff[hte_pkg::ERR_LAT-2] | (|big_d_ff)
                  | (|shifted[hte_pkg::SH_W-1:hte_pkg::ERR_WIDTH]);
   assign err_in_val = clip ? hte_pkg::ERR_MAX : shifted[hte_pkg::ERR_WIDTH-1:0];

   always_ff @(posedge clock) begin
      // range flags are formed at the third stage and ride one more to meet the squares
      big_ff   <= big_in;
      big_d_ff <= big_ff;
      degen_ff <= {degen_ff[hte_pkg::ERR_LAT-2:0], err_in.degen};
      err_ff   <= err_in_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[hte_pkg::ERR_LAT-2:0], err_in.valid};
      end
   end

   assign out_valid     = vld_ff[hte_pkg::ERR_LAT-1];
   assign half_sq_error = err_ff;
   assign degenerate    = degen_ff[hte_pkg::ERR_LAT-1];

endmodule

// ----- hw/rtl/homography_transfer_error.sv -----
// ----------------------------------------------------------------------------
// homography_transfer_error
// Scores one point pair against a 3x3 homography: half the squared distance
// between H applied to the source point and the destination point. A new
// transaction is taken on every cycle that start is high; busy is low except
// during reset. Each result appears on the rsp_ ports for one cycle with
// rsp_valid, in order; the receiver has no way to hold results off. The
// pipeline is the 52-stage bit-per-stage divider (one for each projected
// coordinate) plus three stages of matrix products and sums in front and
// five stages of error arithmetic behind. The user must write the matrix
// rows on the csr_ port only while no transaction is in flight; the block
// does not enforce this.
// ----------------------------------------------------------------------------
module homography_transfer_error (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [hte_pkg::COORD_WIDTH-1:0]  req_src_x,
   input  logic signed [hte_pkg::COORD_WIDTH-1:0]  req_src_y,
   input  logic signed [hte_pkg::COORD_WIDTH-1:0]  req_dst_x,
   input  logic signed [hte_pkg::COORD_WIDTH-1:0]  req_dst_y,
   input  logic                                    csr_wr_en,
   input  logic [hte_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [hte_pkg::CFG_WIDTH-1:0]           csr_wr_data,
   output logic                                    rsp_valid,
   output logic [hte_pkg::ERR_WIDTH-1:0]           rsp_half_sq_error,
   output logic                                    rsp_degenerate
);

   hte_pkg::rows_type     rows_ff, rows_in;
   hte_pkg::map_out_type  map_out;
   hte_pkg::quot_type     quot0, quot1;
   hte_pkg::side_type     side_ff [hte_pkg::DIV_LAT];
   logic [hte_pkg::DIV_LAT-1:0] dvld_ff;
   hte_pkg::err_in_type   err_in;
   logic                  accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      rows_in = rows_ff;
      if (csr_wr_en) begin
         case (csr_index)
            hte_pkg::CSR_ROW_ZERO: rows_in[0] = csr_wr_data;
            hte_pkg::CSR_ROW_ONE:  rows_in[1] = csr_wr_data;
            hte_pkg::CSR_ROW_TWO:  rows_in[2] = csr_wr_data;
            default:               rows_in    = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else begin
         rows_ff <= rows_in;
      end
   end

   hte_map u_map (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .src_x    (req_src_x),
      .src_y    (req_src_y),
      .dst_x    (req_dst_x),
      .dst_y    (req_dst_y),
      .rows     (rows_ff),
      .map_out  (map_out)
   );

   hte_divider u_div_x (
      .clock    (clock),
      .num      (map_out.num[0]),
      .den      (map_out.den),
      .quot_out (quot0)
   );

   hte_divider u_div_y (
      .clock    (clock),
      .num      (map_out.num[1]),
      .den      (map_out.den),
      .quot_out (quot1)
   );

   // sideband rides alongside the divider stages
   always_ff @(posedge clock) begin
      side_ff[0].neg   <= map_out.neg;
      side_ff[0].degen <= map_out.degen;
      side_ff[0].dst   <= map_out.dst;
      for (int s = 1; s < hte_pkg::DIV_LAT; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= '0;
      end else begin
         dvld_ff <= {dvld_ff[hte_pkg::DIV_LAT-2:0], map_out.valid};
      end
   end

   assign err_in.valid   = dvld_ff[hte_pkg::DIV_LAT-1];
   assign err_in.quot[0] = quot0.quot;
   assign err_in.quot[1] = quot1.quot;
   assign err_in.sat     = {quot1.sat, quot0.sat};
   assign err_in.neg     = side_ff[hte_pkg::DIV_LAT-1].neg;
   assign err_in.degen   = side_ff[hte_pkg::DIV_LAT-1].degen;
   assign err_in.dst     = side_ff[hte_pkg::DIV_LAT-1].dst;

   hte_error u_error (
      .clock         (clock),
      .reset         (reset),
      .err_in        (err_in),
      .out_valid     (rsp_valid),
      .half_sq_error (rsp_half_sq_error),
      .degenerate    (rsp_degenerate)
   );

endmodule

// ----- hw/rtl/hte_checker.sv -----
// ----------------------------------------------------------------------------
// hte_checker
// Port-level checks on transaction timing and the degenerate result.
// ----------------------------------------------------------------------------
`include "homography_transfer_error_assert.svh"

module hte_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [hte_pkg::ERR_WIDTH-1:0]   rsp_half_sq_error,
   input logic                            rsp_degenerate
);

   // every taken transaction yields a result after the fixed latency
   `HTE_ASSERT_DELAY(a_result_follows, start && !busy, hte_pkg::LATENCY, rsp_valid, "transaction without result")

   // no result without a transaction taken one latency earlier
   `HTE_ASSERT_NOW(a_no_spurious, rsp_valid, $past(start && !busy, hte_pkg::LATENCY), "result without transaction")

   // zero third component always reports a saturated error
   `HTE_ASSERT_NOW(a_degen_saturates, rsp_valid && rsp_degenerate, &rsp_half_sq_error, "degenerate result not saturated")

endmodule

bind homography_transfer_error hte_checker u_checker (.*);

// ----- verif/tb_homography_transfer_error.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_homography_transfer_error
// Self-checking bench for the homography transfer error scorer. A driver
// feeds point pairs from a queue with random idle cycles. An in-bench scorer
// predicts each score from its own copy of the matrix rows. A monitor checks
// every strobed result in order. The run goes through reset, identity,
// saturating, degenerate and random matrices.
// ----------------------------------------------------------------------------
module tb_homography_transfer_error;

   typedef logic signed [hte_pkg::COORD_WIDTH-1:0] coord_type;

   typedef struct {
      coord_type src_x;
      coord_type src_y;
      coord_type dst_x;
      coord_type dst_y;
   } pair_type;

   typedef struct {
      logic [hte_pkg::ERR_WIDTH-1:0] half_sq_error;
      logic                          degenerate;
   } score_type;

   // unused register slot; writes to it must be dropped
   localparam logic [hte_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam coord_type COORD_MAX = {1'b0, {(hte_pkg::COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(hte_pkg::COORD_WIDTH-1){1'b0}}};
   localparam int        COEF_MAX  = (1 << (hte_pkg::COEF_WIDTH - 1)) - 1;
   localparam int        COEF_MIN  = -(1 << (hte_pkg::COEF_WIDTH - 1));
   localparam int        Q10_ONE   = 1024;

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            start       = 1'b0;
   logic                            busy;
   coord_type                       req_src_x   = '0;
   coord_type                       req_src_y   = '0;
   coord_type                       req_dst_x   = '0;
   coord_type                       req_dst_y   = '0;
   logic                            csr_wr_en   = 1'b0;
   logic [hte_pkg::CSR_IDX_W-1:0]   csr_index   = '0;
   logic [hte_pkg::CFG_WIDTH-1:0]   csr_wr_data = '0;
   logic                            rsp_valid;
   logic [hte_pkg::ERR_WIDTH-1:0]   rsp_half_sq_error;
   logic                            rsp_degenerate;

   hte_pkg::rows_type coef_rows = '0;
   pair_type          pair_queue[$];
   score_type         expected_scores[$];
   pair_type          cur_pair;
   int                idle_pct   = 24;
   int                fail_count = 0;

   homography_transfer_error dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_src_x         (req_src_x),
      .req_src_y         (req_src_y),
      .req_dst_x         (req_dst_x),
      .req_dst_y         (req_dst_y),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_half_sq_error (rsp_half_sq_error),
      .rsp_degenerate    (rsp_degenerate)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_400_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- scorer

   // signed num/den in Q.12, magnitude truncated, saturated at 2^51
   function automatic longint project_coord(input longint num, input longint den);
      bit [63:0] n, d, qi, rm, m;
      n  = (num < 0) ? -num : num;
      d  = (den < 0) ? -den : den;
      qi = n / d;
      rm = n % d;
      if (qi >= (64'd1 << 39))
         m = 64'd1 << hte_pkg::QUOT_W;
      else
         m = (qi << hte_pkg::QUOT_FRAC) | ((rm << hte_pkg::QUOT_FRAC) / d);
      return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
   endfunction

   // maps the source point through the current matrix, Q.12 result
   function automatic void map_point(input coord_type sx, input coord_type sy,
                                     output longint px, output longint py,
                                     output bit at_infinity);
      longint                                h [hte_pkg::NUM_ROWS][3];
      longint                                w [hte_pkg::NUM_ROWS];
      logic signed [hte_pkg::COEF_WIDTH-1:0] cf;
      for (int r = 0; r < hte_pkg::NUM_ROWS; r++) begin
         for (int c = 0; c < 3; c++) begin
            cf = coef_rows[r][c*hte_pkg::COEF_WIDTH +: hte_pkg::COEF_WIDTH];
            h[r][c] = longint'(cf);
         end
         w[r] = h[r][0] * longint'(sx) + h[r][1] * longint'(sy) + h[r][2] * 256;
      end
      at_infinity = (w[2] == 0);
      px = 0;
      py = 0;
      if (!at_infinity) begin
         px = project_coord(w[0], w[2]);
         py = project_coord(w[1], w[2]);
      end
   endfunction

   function automatic score_type score_pair(input pair_type p);
      score_type s;
      longint    px, py, ex, ey;
      bit        flat;
      bit [63:0] ax, ay, sum;
      map_point(p.src_x, p.src_y, px, py, flat);
      if (flat) begin
         s.half_sq_error = hte_pkg::ERR_MAX;
         s.degenerate    = 1'b1;
      end else begin
         ex = px - longint'(p.dst_x) * 16;
         ey = py - longint'(p.dst_y) * 16;
         ax = (ex < 0) ? -ex : ex;
         ay = (ey < 0) ? -ey : ey;
         s.degenerate = 1'b0;
         if (ax >= (64'd1 << hte_pkg::EMAG_W) || ay >= (64'd1 << hte_pkg::EMAG_W)) begin
            s.half_sq_error = hte_pkg::ERR_MAX;
         end else begin
            sum = (ax * ax + ay * ay) >> hte_pkg::ERR_SHIFT;
            s.half_sq_error = (sum > 64'(hte_pkg::ERR_MAX)) ? hte_pkg::ERR_MAX
                                                            : sum[hte_pkg::ERR_WIDTH-1:0];
         end
      end
      return s;
   endfunction

   // ----------------------------------------------------- driver and monitor

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            expected_scores.insert(expected_scores.size(), score_pair(cur_pair));
         if (start && busy) begin
            // not taken yet, hold the transaction
         end else if (pair_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            cur_pair = pair_queue.pop_front();
            start     <= 1'b1;
            req_src_x <= cur_pair.src_x;
            req_src_y <= cur_pair.src_y;
            req_dst_x <= cur_pair.dst_x;
            req_dst_y <= cur_pair.dst_y;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      score_type want;
      if (!reset && rsp_valid) begin
         if (expected_scores.size() == 0) begin
            $error("result strobed with no transaction outstanding");
            fail_count++;
         end else begin
            want = expected_scores.pop_front();
            if (rsp_half_sq_error !== want.half_sq_error) begin
               $error("half_sq_error: expected %0h, got %0h",
                      want.half_sq_error, rsp_half_sq_error);
               fail_count++;
            end
            if (rsp_degenerate !== want.degenerate) begin
               $error("degenerate: expected %0b, got %0b",
                      want.degenerate, rsp_degenerate);
               fail_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------- stimulus

   function automatic int rnd_int(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic logic [hte_pkg::CFG_WIDTH-1:0] pack_row(input int c0, input int c1,
                                                               input int c2);
      return {hte_pkg::COEF_WIDTH'(c2), hte_pkg::COEF_WIDTH'(c1), hte_pkg::COEF_WIDTH'(c0)};
   endfunction

   function automatic coord_type rand_coord();
      int v;
      case ($urandom_range(3))
         0:       v = int'($urandom);
         1:       v = rnd_int(-256, 255);
         default: v = rnd_int(-1048576, 1048575);
      endcase
      return coord_type'(v);
   endfunction

   function automatic coord_type clamp_coord(input longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_type'(v);
   endfunction

   // mostly sub-pixel to a few pixels off, sometimes far off
   function automatic longint pick_noise();
      if ($urandom_range(9) == 0)
         return longint'(rnd_int(-524288, 524288));
      return longint'(rnd_int(-512, 512));
   endfunction

   task automatic queue_pair(input coord_type sx, input coord_type sy,
                             input coord_type dx, input coord_type dy);
      pair_type p;
      p.src_x = sx;
      p.src_y = sy;
      p.dst_x = dx;
      p.dst_y = dy;
      pair_queue.insert(pair_queue.size(), p);
   endtask

   // aimed pairs put the destination near the mapped source point
   task automatic queue_random_pairs(input int n, input int aim_pct, input int tie_pct);
      pair_type p;
      longint   px, py;
      bit       flat;
      for (int i = 0; i < n; i++) begin
         p.src_x = rand_coord();
         p.src_y = ($urandom_range(99) < tie_pct) ? p.src_x : rand_coord();
         p.dst_x = rand_coord();
         p.dst_y = rand_coord();
         if ($urandom_range(99) < aim_pct) begin
            map_point(p.src_x, p.src_y, px, py, flat);
            if (!flat) begin
               p.dst_x = clamp_coord(longint'(clamp_coord(px >>> hte_pkg::DST_SHIFT))
                                     + pick_noise());
               p.dst_y = clamp_coord(longint'(clamp_coord(py >>> hte_pkg::DST_SHIFT))
                                     + pick_noise());
            end
         end
         pair_queue.insert(pair_queue.size(), p);
      end
   endtask

   task automatic write_csr(input logic [hte_pkg::CSR_IDX_W-1:0] idx,
                            input logic [hte_pkg::CFG_WIDTH-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      if (idx < hte_pkg::NUM_ROWS)
         coef_rows[idx] = data;
   endtask

   task automatic load_matrix(input logic [hte_pkg::CFG_WIDTH-1:0] r0,
                              input logic [hte_pkg::CFG_WIDTH-1:0] r1,
                              input logic [hte_pkg::CFG_WIDTH-1:0] r2, input bit spare);
      if (spare)
         write_csr(CSR_SPARE, hte_pkg::CFG_WIDTH'({$urandom, $urandom}));
      write_csr(hte_pkg::CSR_ROW_ZERO, r0);
      write_csr(hte_pkg::CSR_ROW_ONE, r1);
      write_csr(hte_pkg::CSR_ROW_TWO, r2);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // near-rigid rows with a small perspective term
   task automatic load_scene(input bit spare);
      int h22;
      h22 = ($urandom_range(1) != 0) ? rnd_int(512, 2047) : -rnd_int(512, 2047);
      load_matrix(pack_row(rnd_int(512, 1536), rnd_int(-256, 256), rnd_int(COEF_MIN, COEF_MAX)),
                  pack_row(rnd_int(-256, 256), rnd_int(512, 1536), rnd_int(COEF_MIN, COEF_MAX)),
                  pack_row(rnd_int(-1, 1), rnd_int(-1, 1), h22), spare);
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (pair_queue.size() != 0 || start || expected_scores.size() != 0);
   endtask

   initial begin : stimulus
      int a;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // rows still at reset: every point maps to infinity
      queue_pair(0, 0, 0, 0);
      queue_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      queue_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      drain();

      // identity; also a write to the unused slot that must not land
      load_matrix(pack_row(Q10_ONE, 0, 0), pack_row(0, Q10_ONE, 0),
                  pack_row(0, 0, Q10_ONE), 1'b1);
      queue_pair(0, 0, 0, 0);
      queue_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      queue_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      queue_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      queue_pair(1, 0, 0, 0);
      queue_pair(-1, 1, 0, 0);
      queue_pair(25600, -12800, 25000, -13000);
      drain();

      // w2 = x: unit divisor saturates the quotient, zero x is degenerate
      load_matrix(pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                  pack_row(COEF_MIN, COEF_MIN, COEF_MIN), pack_row(1, 0, 0), 1'b0);
      queue_pair(1, 0, 0, 0);
      queue_pair(-1, 0, COORD_MAX, COORD_MIN);
      queue_pair(0, COORD_MAX, 0, 0);
      queue_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      drain();

      // all coefficients at the top
      load_matrix(pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                  pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                  pack_row(COEF_MAX, COEF_MAX, COEF_MAX), 1'b0);
      queue_pair(COORD_MAX, COORD_MAX, 0, 0);
      queue_pair(5, -5, 256, 256);
      queue_pair(-128, -128, 0, 0);
      drain();

      // all coefficients at the bottom
      load_matrix(pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                  pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                  pack_row(COEF_MIN, COEF_MIN, COEF_MIN), 1'b0);
      queue_pair(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
      queue_pair(100, 200, -50, 60);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         idle_pct = (ph == 1) ? 0 : 24;
         case (ph % 4)
            0, 1: begin
               load_scene(ph == 4);
               queue_random_pairs(200, 80, 3);
            end
            2: begin
               load_matrix(hte_pkg::CFG_WIDTH'({$urandom, $urandom}),
                           hte_pkg::CFG_WIDTH'({$urandom, $urandom}),
                           hte_pkg::CFG_WIDTH'({$urandom, $urandom}), 1'b0);
               queue_random_pairs(200, 70, 3);
            end
            default: begin
               // w2 = a*(x - y): equal coordinates hit the degenerate case
               a = rnd_int(1, 2000) * (($urandom_range(1) != 0) ? 1 : -1);
               load_matrix(pack_row(rnd_int(512, 1536), rnd_int(-256, 256), rnd_int(-4096, 4096)),
                           pack_row(rnd_int(-256, 256), rnd_int(512, 1536), rnd_int(-4096, 4096)),
                           pack_row(a, -a, 0), 1'b0);
               queue_random_pairs(200, 70, 20);
            end
         endcase
         drain();
      end

      repeat (hte_pkg::LATENCY + 8) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
